// File: sv/assert_macros.svh
// assertion macros shared by the checker files
// each check is clocked on the rising edge and muted while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check
`define U8D_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check of an implication whose effect is checked in the next cycle
`define U8D_ASSERT_NEXT(lbl, cause, effect, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// File: sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the utf-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int ByteW  = 8;
   localparam int CpW    = 22;
   localparam int PendW  = 2;
   localparam int RspDataW = ((CpW + 7) / 8) * 8;

   // lead byte thresholds and markers
   localparam logic [ByteW-1:0] AsciiLimit  = 8'h80;
   localparam logic [ByteW-1:0] ThreeLimit  = 8'hE0;
   localparam logic [ByteW-1:0] FourLimit   = 8'hF0;
   localparam logic [ByteW-1:0] TwoMarker   = 8'hC0;
   localparam logic [ByteW-1:0] ThreeMarker = 8'hE0;
   localparam logic [ByteW-1:0] FourMarker  = 8'hF0;
   localparam logic [ByteW-1:0] ContMarker  = 8'h80;

   // continuation bytes still expected after each lead kind
   localparam logic [PendW-1:0] PendNone  = 2'd0;
   localparam logic [PendW-1:0] PendTwo   = 2'd1;
   localparam logic [PendW-1:0] PendThree = 2'd2;
   localparam logic [PendW-1:0] PendFour  = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] text_byte;
      logic             string_end;
   } req_item_type;

   typedef struct packed {
      logic [CpW-1:0] code_point;
      logic           point_valid;
      logic           string_done;
   } rsp_item_type;

endpackage

// File: sv/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register: holds one request until the decoder consumes it.
// ----------------------------------------------------------------------------
module u8d_in_stage
   import u8d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         stage_valid,
   output req_item_type stage_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   // take a new request when empty or when the held one leaves
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// File: sv/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state and the shift-or decode of one byte.
// ----------------------------------------------------------------------------
module u8d_decode
   import u8d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         stage_valid,
   input  req_item_type stage_item,
   input  logic         out_free,
   output logic         advance,
   output logic         res_valid,
   output rsp_item_type res_item
);

   logic [PendW-1:0] pending_ff, pending_in;
   logic [CpW-1:0]   partial_ff, partial_in;
   logic [PendW-1:0] pend_next;
   logic [CpW-1:0]   part_next;
   logic [CpW-1:0]   cp;
   logic             complete;
   logic             has_result;
   logic [ByteW-1:0] b;

   assign b = stage_item.text_byte;

   // decode of the held byte against the current sequence
   always_comb begin
      complete  = 1'b0;
      cp        = '0;
      pend_next = pending_ff;
      part_next = partial_ff;
      if (pending_ff == PendNone) begin
         if (b < AsciiLimit) begin
            complete = 1'b1;
            cp       = CpW'(b);
         end else if (b < ThreeLimit) begin
            part_next = CpW'(b ^ TwoMarker);
            pend_next = PendTwo;
         end else if (b < FourLimit) begin
            part_next = CpW'(b ^ ThreeMarker);
            pend_next = PendThree;
         end else begin
            part_next = CpW'(b ^ FourMarker);
            pend_next = PendFour;
         end
      end else begin
         part_next = {partial_ff[CpW-7:0], 6'b0} | CpW'(b ^ ContMarker);
         pend_next = pending_ff - PendW'(1);
         if (pend_next == PendNone) begin
            complete = 1'b1;
            cp       = part_next;
         end
      end
   end

   // a result goes out on a completed character or the string end
   assign has_result = stage_item.string_end || complete;
   assign advance    = stage_valid && (!has_result || out_free);
   assign res_valid  = advance && has_result;

   always_comb begin
      res_item.code_point  = complete ? cp : '0;
      res_item.point_valid = complete;
      res_item.string_done = stage_item.string_end;
   end

   // state update when the byte is consumed
   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      if (advance) begin
         if (stage_item.string_end) begin
            pending_in = PendNone;
            partial_in = '0;
         end else if (complete) begin
            pending_in = pend_next;
            partial_in = '0;
         end else begin
            pending_in = pend_next;
            partial_in = part_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PendNone;
         partial_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// File: sv/u8d_out_stage.sv
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register on the response side.
// ----------------------------------------------------------------------------
module u8d_out_stage
   import u8d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   input  rsp_item_type res_item,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // register is free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         item_in  = res_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: sv/utf8_to_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit
// Decodes a utf-8 byte stream into code points, one byte per cycle while no response is stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one string byte per request in req_tdata, req_tlast high on
//   the final byte of a string.
//   rsp channel: one response per completed character or final byte of a
//   string, just one if both. rsp_tdata carries the code point, rsp_tuser
//   is high when it holds a completed character, rsp_tlast marks the
//   response for the string's final byte (a cut-off sequence gives tuser low
//   and a zero code point).
//   Path: an accepted request is held in the input register, decoded from
//   there and written to the result register once that register is free.
//   Throughput: one request per cycle unless a response is stalled, set by
//   the shift-or update of the sequence state between the two registers.
//   Stall: while rsp_tready is low a held response stays put; bytes that
//   produce no response keep flowing, and one more request is buffered in
//   the input register before req_tready drops.
//   Reset: both registers empty, no sequence in progress.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit
   import u8d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                req_tlast,   // string_end
   // response
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [21:0] code_point, rest zero
   output logic                rsp_tuser,   // point_valid
   output logic                rsp_tlast    // string_done
);

   req_item_type req_item;
   req_item_type stage_item;
   rsp_item_type res_item;
   rsp_item_type rsp_item;
   logic         stage_valid;
   logic         advance;
   logic         out_free;
   logic         res_valid;

   assign req_item.text_byte  = req_tdata;
   assign req_item.string_end = req_tlast;

   // input register
   u8d_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   // decode and sequence state
   u8d_decode u_dec (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .out_free    (out_free),
      .advance     (advance),
      .res_valid   (res_valid),
      .res_item    (res_item)
   );

   // result register
   u8d_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_item  (res_item),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = RspDataW'(rsp_item.code_point);
   assign rsp_tuser = rsp_item.point_valid;
   assign rsp_tlast = rsp_item.string_done;

endmodule

// File: sv/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_checker
   import u8d_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tuser,
   input logic                rsp_tlast
);

   // a stalled response holds its contents
   `U8D_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "response changed while stalled")

   // a response without a character only ends a string
   `U8D_ASSERT(a_invalid_is_last, rsp_tvalid && !rsp_tuser |-> rsp_tlast, "empty response not at string end")

   // a dropped sequence reports a zero code point
   `U8D_ASSERT(a_invalid_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "empty response with nonzero data")

   // padding bits above the code point stay zero
   `U8D_ASSERT(a_pad_zero, rsp_tvalid |-> (rsp_tdata >> CpW) == '0, "code point padding not zero")

endmodule

bind utf8_to_codepoint_decoder_unit u8d_checker u_u8d_checker (.*);

// File: bench/tb_utf8_to_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_to_codepoint_decoder_unit
// Self-checking bench for the utf-8 to code point decoder.
// A directed set of byte strings is followed by random strings. Most random
// strings are well-formed utf-8, and the rest mix in stray bytes and cut-off
// sequences. A byte-level decoder model predicts every response, and the
// monitor compares each accepted response with the oldest prediction. Both
// channels idle at random. One long receiver hold-off backs up the block,
// and the sender drains all responses twice before going on.
// ----------------------------------------------------------------------------
module tb_utf8_to_codepoint_decoder_unit;
   import u8d_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;

   // one planned request, or a pause until all responses are back
   typedef struct {
      logic [ByteW-1:0] text_byte;
      logic             string_end;
      bit               drain;
   } text_plan_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ByteW-1:0]    req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   text_plan_type text_queue[$];
   rsp_item_type  point_queue[$];

   // decoder model state
   logic [PendW-1:0] pend_left = PendNone;
   logic [CpW-1:0]   part_value = '0;

   int  cycle_count = 0;
   int  error_count = 0;
   int  accepted_reqs = 0;
   int  planned_bytes = 0;
   bit  req_sent = 1'b0;
   bit  stim_done = 1'b0;
   int  send_gap = 0;
   int  send_calm = 0;
   int  stall_left = 0;
   int  rsp_calm = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   utf8_to_codepoint_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // decode one byte; returns 1 when the byte produces a response
   function automatic bit decode_text_byte(input logic [ByteW-1:0] text,
                                           input logic fin,
                                           output rsp_item_type point);
      logic [CpW-1:0] cp;
      bit             complete;
      complete = 1'b0;
      cp = '0;
      point = '0;
      if (pend_left == PendNone) begin
         // lead byte picks the sequence length
         if (text < AsciiLimit) begin
            cp = CpW'(text);
            complete = 1'b1;
         end else if (text < ThreeLimit) begin
            part_value = CpW'(text ^ TwoMarker);
            pend_left = PendTwo;
         end else if (text < FourLimit) begin
            part_value = CpW'(text ^ ThreeMarker);
            pend_left = PendThree;
         end else begin
            part_value = CpW'(text ^ FourMarker);
            pend_left = PendFour;
         end
      end else begin
         // continuation byte, not validated
         part_value = {part_value[CpW-7:0], 6'b0} | CpW'(text ^ ContMarker);
         pend_left = pend_left - 1'b1;
         if (pend_left == PendNone) begin
            cp = part_value;
            complete = 1'b1;
         end
      end
      if (fin) begin
         // final byte always answers; a cut-off sequence gives a zero point
         point.code_point = complete ? cp : '0;
         point.point_valid = complete;
         point.string_done = 1'b1;
         pend_left = PendNone;
         part_value = '0;
         return 1'b1;
      end
      if (complete) begin
         point.code_point = cp;
         point.point_valid = 1'b1;
         point.string_done = 1'b0;
         part_value = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic add_byte(input logic [ByteW-1:0] text, input logic fin);
      text_plan_type p;
      p.text_byte = text;
      p.string_end = fin;
      p.drain = 1'b0;
      text_queue = {text_queue, p};
      planned_bytes++;
   endtask

   task automatic add_drain();
      text_plan_type p;
      p.text_byte = '0;
      p.string_end = 1'b0;
      p.drain = 1'b1;
      text_queue = {text_queue, p};
   endtask

   // one random string: mostly well-formed characters, some stray bytes,
   // and now and then a trailing lead byte with up to two continuation bytes
   task automatic add_random_string();
      logic [ByteW-1:0] seq[$];
      int               n_chars;
      int               kind;
      seq = {};
      n_chars = $urandom_range(1, 10);
      for (int c = 0; c < n_chars; c++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            seq = {seq, ByteW'($urandom_range(0, 127))};
         end else if (kind < 60) begin
            seq = {seq, ByteW'($urandom_range(8'hC0, 8'hDF))};
            seq = {seq, ByteW'($urandom_range(8'h80, 8'hBF))};
         end else if (kind < 75) begin
            seq = {seq, ByteW'($urandom_range(8'hE0, 8'hEF))};
            repeat (2) seq = {seq, ByteW'($urandom_range(8'h80, 8'hBF))};
         end else if (kind < 87) begin
            seq = {seq, ByteW'($urandom_range(8'hF0, 8'hF7))};
            repeat (3) seq = {seq, ByteW'($urandom_range(8'h80, 8'hBF))};
         end else begin
            seq = {seq, ByteW'($urandom_range(0, 255))};
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         // lead byte plus up to two continuation bytes at the end
         seq = {seq, ByteW'($urandom_range(8'hC0, 8'hFF))};
         repeat ($urandom_range(0, 2))
            seq = {seq, ByteW'($urandom_range(8'h80, 8'hBF))};
      end
      foreach (seq[i]) add_byte(seq[i], i == seq.size() - 1);
   endtask

   // sender gap after each request, with calm stretches and none while
   // the receiver holds off
   function automatic int pick_send_gap();
      int r;
      if (hold_left > 0) return 0;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_sent)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (text_queue.size() > 0 && text_queue[0].drain) begin
            // hold off until every pending response is back
            if (point_queue.size() == 0) void'(text_queue.pop_front());
            req_tvalid <= 1'b0;
         end else if (text_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= text_queue[0].text_byte;
            req_tlast <= text_queue[0].string_end;
            void'(text_queue.pop_front());
            send_gap = pick_send_gap();
         end else begin
            req_tvalid <= 1'b0;
            stim_done = 1'b1;
         end
      end
   end

   // response ready, with one long hold-off once traffic is under way
   always @(negedge clock) begin
      int r;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && accepted_reqs >= 120) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_calm > 0) begin
            rsp_calm--;
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               rsp_calm = $urandom_range(30, 80);
               rsp_tready <= 1'b1;
            end else if (r < 70) begin
               rsp_tready <= 1'b1;
            end else if (r < 96) begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else begin
               stall_left = $urandom_range(8, 30);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // monitor: check responses, then predict from accepted requests
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         req_sent = 1'b0;
      end else begin
         req_sent = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (point_queue.size() == 0) begin
               report_mismatch($sformatf("response %h/%b/%b with nothing pending",
                  rsp_tdata[CpW-1:0], rsp_tuser, rsp_tlast));
            end else begin
               want = point_queue.pop_front();
               if (rsp_tdata[CpW-1:0] !== want.code_point)
                  report_mismatch($sformatf("code point %h, want %h",
                     rsp_tdata[CpW-1:0], want.code_point));
               if (rsp_tuser !== want.point_valid)
                  report_mismatch($sformatf("point valid %b, want %b",
                     rsp_tuser, want.point_valid));
               if (rsp_tlast !== want.string_done)
                  report_mismatch($sformatf("string done %b, want %b",
                     rsp_tlast, want.string_done));
            end
         end
         if (req_sent) begin
            accepted_reqs++;
            if (decode_text_byte(req_tdata, req_tlast, got)) point_queue = {point_queue, got};
         end
      end
   end

   // directed strings; bit 8 marks the final byte of a string
   logic [8:0] directed_list[] = '{
      9'h000,                          // nul byte, string goes on
      9'h07F,                          // top ascii byte
      9'h0C3, 9'h0A9,                  // two-byte character
      9'h0E2, 9'h082, 9'h0AC,          // three-byte character
      9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte character
      9'h080, 9'h0BF,                  // stray continuation as lead
      9'h0FF, 9'h0FF, 9'h000, 9'h07F,  // 0xff lead, odd continuations
      9'h0E2, 9'h182,                  // string cut off mid-sequence
      9'h141,                          // ascii final byte
      9'h0DF, 9'h1BF                   // final byte completes a character
   };

   // stimulus plan and end of run
   initial begin
      foreach (directed_list[i]) add_byte(directed_list[i][7:0], directed_list[i][8]);
      add_drain();
      while (planned_bytes < 260) add_random_string();
      add_drain();
      while (planned_bytes < 470) add_random_string();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!(stim_done && point_queue.size() == 0)) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: utf8_to_codepoint_decoder_unit.f
+incdir+sv
sv/u8d_pkg.sv
sv/u8d_in_stage.sv
sv/u8d_decode.sv
sv/u8d_out_stage.sv
sv/utf8_to_codepoint_decoder_unit.sv
sv/u8d_checker.sv
bench/tb_utf8_to_codepoint_decoder_unit.sv
